/* hdl/dscv_pkg.sv */
package dscv_pkg;

	localparam int ClassCount = 10;
	localparam int WindowMax = 16;
	localparam int ClsW = 4;
	localparam int SlotW = 4;
	localparam int FillW = 5;
	localparam int AccW = 40;
	localparam logic [15:0] UniformCert = 16'((65536 + ClassCount / 2) / ClassCount);
	localparam logic [4:0] WindowReset = 5'd12;

	// Exp table in Q2.14: round(16384 * e^(k/255)).
	function automatic logic [15:0] exp_lut(input logic [7:0] k);
		logic [63:0] term;
		logic [63:0] sum;
		sum = 64'd0;
		term = 64'd1 << 40;
		for (int n = 1; n <= 24; n++) begin
			sum = sum + term;
			term = (term * 64'(k)) / 64'(255 * n);
		end
		sum = sum + term;
		return 16'((sum + (64'd1 << 25)) >> 26);
	endfunction

	// Decay weights in Q1.16 by age.
	function automatic logic [16:0] decay_weight(input logic [SlotW-1:0] age);
		logic [63:0] p;
		logic [95:0] t;
		p = 64'd1 << 32;
		for (int a = 1; a < WindowMax; a++) begin
			if (a <= int'(age)) begin
				t = 96'(p) * 96'd3516421809 + (96'd1 << 31);
				p = 64'(t >> 32);
			end
		end
		if (age == '0) return 17'd65536;
		return 17'((p + (64'd1 << 15)) >> 16);
	endfunction

	typedef struct packed {
		logic        start;
		logic [31:0] num;
		logic [31:0] den;
	} div_req_t;

	typedef struct packed {
		logic        busy;
		logic        done;
		logic [31:0] quo;
	} div_rsp_t;

endpackage

/* hdl/dscv_divider.sv */
module dscv_divider
	import dscv_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic [31:0] quo_q;
	logic [32:0] rem_q;
	logic [31:0] den_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [32:0] trial;

	// One quotient bit a cycle, restoring.
	assign trial = {rem_q[31:0], quo_q[31]} - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= 6'd32;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.num;
			den_q <= req.den;
			rem_q <= '0;
		end else if (busy_q) begin
			if (!trial[32]) begin
				rem_q <= trial;
				quo_q <= {quo_q[30:0], 1'b1};
			end else begin
				rem_q <= {rem_q[31:0], quo_q[31]};
				quo_q <= {quo_q[30:0], 1'b0};
			end
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.quo = quo_q;

endmodule

/* hdl/decayed_softmax_class_vote.sv */
// Channel | Signals                              | Direction
// in      | in_valid, in_ready, score_0..score_9 | into block
// out     | out_valid, out_ready, raw_class,     | out of block
//         | smoothed_class                       |
// cfg     | cfg_valid, cfg_ready, cfg_data       | into block
// Each item makes twenty divisions through the shared bit-serial divider, one
// multiply-add per history entry summed, then the vote and one hand-over.
// An all-zero frame does not wait for the divisions.
// Reset empties the history; entries are written before they are read.
// A result waits in the output register; only a second finished result stalls.
module decayed_softmax_class_vote
	import dscv_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [15:0] score_0, score_1, score_2, score_3, score_4,
	input  logic [15:0] score_5, score_6, score_7, score_8, score_9,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [3:0]  raw_class,
	output logic [3:0]  smoothed_class,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [4:0]  cfg_data
);

	typedef enum logic [7:0] {
		ST_IDLE  = 8'b00000001,
		ST_NORM  = 8'b00000010,
		ST_NWAIT = 8'b00000100,
		ST_CERT  = 8'b00001000,
		ST_CWAIT = 8'b00010000,
		ST_ACC   = 8'b00100000,
		ST_PICK  = 8'b01000000,
		ST_OUT   = 8'b10000000
	} state_t;

	state_t state_q;
	logic [15:0] sc_q [ClassCount];
	logic [15:0] ex_q [ClassCount];
	logic [AccW-1:0] acc_q [ClassCount];
	logic [15:0] hist_mem [WindowMax*ClassCount];
	logic [15:0] rd_q;
	logic [15:0] mx_q;
	logic [ClsW-1:0] raw_q, best_q, cls_q;
	logic [19:0] sum_q;
	logic [4:0] win_q;
	logic [FillW-1:0] fill_q, cnt_q;
	logic [SlotW-1:0] slot_q, age_q;
	logic rd_v_q;
	logic out_v_q;
	logic [ClsW-1:0] out_raw_q, out_best_q;
	div_req_t dreq;
	div_rsp_t drsp;
	logic [15:0] sc_in [ClassCount];
	logic [15:0] mx_c;
	logic [ClsW-1:0] raw_c;
	logic [4:0] len_c;
	logic [SlotW-1:0] rd_slot;
	logic [7:0] rd_addr;
	logic [31:0] k_c;
	logic [16:0] cert_c;
	logic [15:0] exp_rom [256];
	logic [16:0] weight_rom [WindowMax];

	dscv_divider u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .rsp(drsp));

	// Constant tables: exp values by normalised level and decay weights by age.
	for (genvar g = 0; g < 256; g++) begin : g_exp
		assign exp_rom[g] = exp_lut(8'(g));
	end
	for (genvar g = 0; g < WindowMax; g++) begin : g_weight
		assign weight_rom[g] = decay_weight(SlotW'(g));
	end

	assign sc_in = '{score_0, score_1, score_2, score_3, score_4,
		score_5, score_6, score_7, score_8, score_9};

	// Maximum of the raw scores, lowest index on ties.
	always_comb begin
		mx_c = '0;
		raw_c = '0;
		for (int i = 0; i < ClassCount; i++) begin
			if (sc_in[i] > mx_c) begin
				mx_c = sc_in[i];
				raw_c = ClsW'(i);
			end
		end
	end

	assign in_ready = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign out_valid = out_v_q;
	assign raw_class = out_raw_q;
	assign smoothed_class = out_best_q;

	assign len_c = (win_q == 5'd0) ? 5'd1 : (win_q > 5'(WindowMax)) ? 5'(WindowMax) : win_q;
	assign rd_slot = slot_q - age_q;
	assign rd_addr = 8'(rd_slot) * 8'(ClassCount) + 8'(cls_q);
	assign k_c = (drsp.quo > 32'd255) ? 32'd255 : drsp.quo;
	assign cert_c = (drsp.quo > 32'd65535) ? 17'd65535 : drsp.quo[16:0];

	// Divider requests.
	always_comb begin
		dreq.start = 1'b0;
		dreq.num = '0;
		dreq.den = 32'd1;
		if (state_q == ST_NORM) begin
			dreq.start = 1'b1;
			dreq.num = 32'd255 * 32'(sc_q[cls_q]) + 32'(mx_q >> 1);
			dreq.den = 32'(mx_q);
		end else if (state_q == ST_CERT) begin
			dreq.start = 1'b1;
			dreq.num = {ex_q[cls_q], 16'd0} + 32'(sum_q >> 1);
			dreq.den = 32'(sum_q);
		end
	end

	// Register write.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= WindowReset;
		end else if (cfg_valid) begin
			win_q <= cfg_data;
		end
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			fill_q <= '0;
			slot_q <= '0;
			cls_q <= '0;
			age_q <= '0;
			rd_v_q <= 1'b0;
		end else begin
			rd_v_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						slot_q <= slot_q + 1'b1;
						if (fill_q < FillW'(WindowMax)) fill_q <= fill_q + 1'b1;
						cls_q <= '0;
						state_q <= (mx_c == '0) ? ST_CERT : ST_NORM;
					end
				end
				ST_NORM: state_q <= ST_NWAIT;
				ST_NWAIT: begin
					if (drsp.done) begin
						if (cls_q == ClsW'(ClassCount - 1)) begin
							cls_q <= '0;
							state_q <= ST_CERT;
						end else begin
							cls_q <= cls_q + 1'b1;
							state_q <= ST_NORM;
						end
					end
				end
				ST_CERT: state_q <= (mx_q == '0) ? ST_CWAIT : ST_CWAIT;
				ST_CWAIT: begin
					if (drsp.done || mx_q == '0) begin
						if (cls_q == ClsW'(ClassCount - 1)) begin
							cls_q <= '0;
							age_q <= '0;
							state_q <= ST_ACC;
						end else begin
							cls_q <= cls_q + 1'b1;
							state_q <= ST_CERT;
						end
					end
				end
				ST_ACC: begin
					rd_v_q <= 1'b1;
					if (cls_q == ClsW'(ClassCount - 1)) begin
						cls_q <= '0;
						if (5'(age_q) + 5'd1 >= cnt_q) begin
							state_q <= ST_PICK;
						end else begin
							age_q <= age_q + 1'b1;
						end
					end else begin
						cls_q <= cls_q + 1'b1;
					end
				end
				ST_PICK: begin
					if (!rd_v_q) begin
						if (cls_q == ClsW'(ClassCount - 1)) state_q <= ST_OUT;
						else cls_q <= cls_q + 1'b1;
					end
				end
				ST_OUT: begin
					if (!out_v_q || out_ready) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Output register: holds a finished result so that the next item can start.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
			out_raw_q <= '0;
			out_best_q <= '0;
		end else if (state_q == ST_OUT && (!out_v_q || out_ready)) begin
			out_v_q <= 1'b1;
			out_raw_q <= raw_q;
			out_best_q <= best_q;
		end else if (out_ready) begin
			out_v_q <= 1'b0;
		end
	end

	// Datapath registers.
	logic [SlotW-1:0] age_s1;
	logic [ClsW-1:0] cls_s1;
	logic [32:0] prod_c;

	// Weighted certainty of the entry read in the previous cycle.
	assign prod_c = 33'(weight_rom[age_s1]) * 33'(rd_q);

	always_ff @(posedge clk) begin
		age_s1 <= age_q;
		cls_s1 <= cls_q;
		rd_q <= hist_mem[rd_addr];
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					sc_q <= sc_in;
					mx_q <= mx_c;
					raw_q <= raw_c;
					sum_q <= '0;
					for (int i = 0; i < ClassCount; i++) acc_q[i] <= '0;
					best_q <= '0;
					cnt_q <= ((fill_q < FillW'(WindowMax) ? fill_q + 1'b1 : fill_q) < len_c) ?
						(fill_q < FillW'(WindowMax) ? fill_q + 1'b1 : fill_q) : len_c;
				end
			end
			ST_NWAIT: begin
				if (drsp.done) begin
					ex_q[cls_q] <= exp_rom[k_c[7:0]];
					sum_q <= sum_q + 20'(exp_rom[k_c[7:0]]);
				end
			end
			ST_CWAIT: begin
				if (mx_q == '0) hist_mem[8'(slot_q) * 8'(ClassCount) + 8'(cls_q)] <= UniformCert;
				else if (drsp.done)
					hist_mem[8'(slot_q) * 8'(ClassCount) + 8'(cls_q)] <= cert_c[15:0];
			end
			ST_PICK: begin
				if (!rd_v_q && cls_q != '0 && acc_q[cls_q] > acc_q[best_q]) best_q <= cls_q;
			end
			default: ;
		endcase
		if (rd_v_q) acc_q[cls_s1] <= acc_q[cls_s1] + AccW'(prod_c);
	end

endmodule

/* dv/decayed_softmax_class_vote_tb.sv */
`timescale 1ns / 1ps

module decayed_softmax_class_vote_tb
	import dscv_pkg::*;
();

	typedef struct {
		logic [15:0] score [ClassCount];
	} frame_t;

	typedef struct {
		logic [3:0] raw_class;
		logic [3:0] smoothed_class;
	} vote_t;

	typedef enum logic [1:0] {
		ACT_FRAME,
		ACT_WINDOW,
		ACT_DRAIN
	} action_t;

	typedef struct {
		action_t     act;
		frame_t      frame;
		logic [4:0]  window;
		logic        no_idle;
	} pending_t;

	localparam int ItemLatency = 1000;
	localparam int StallLimit = 40000;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [15:0] score [ClassCount];
	logic        out_valid;
	logic        out_ready;
	logic [3:0]  raw_class;
	logic [3:0]  smoothed_class;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [4:0]  cfg_data;

	decayed_softmax_class_vote dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.score_0        (score[0]),
		.score_1        (score[1]),
		.score_2        (score[2]),
		.score_3        (score[3]),
		.score_4        (score[4]),
		.score_5        (score[5]),
		.score_6        (score[6]),
		.score_7        (score[7]),
		.score_8        (score[8]),
		.score_9        (score[9]),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.raw_class      (raw_class),
		.smoothed_class (smoothed_class),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_data       (cfg_data)
	);

	// Predictor state: certainty history ring, fill level, newest slot and window.
	logic [15:0] cert_ring [WindowMax][ClassCount];
	int          ring_fill;
	int          ring_head;
	logic [4:0]  window_reg;

	pending_t    pending_q [$];
	vote_t       vote_q [$];
	int          errors;
	int          frames_sent;
	int          votes_seen;
	int          windows_written;
	bit          stim_done;
	int          quiet_cycles;

	// Clock.
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Exp of k/255 in Q2.14 by Taylor series.
	function automatic logic [15:0] exp_of_level(input int unsigned k);
		logic [63:0] term;
		logic [63:0] acc;
		acc = 0;
		term = 64'd1 << 40;
		for (int n = 1; n <= 24; n++) begin
			acc += term;
			term = (term * k) / (255 * n);
		end
		acc += term;
		return 16'((acc + (64'd1 << 25)) >> 26);
	endfunction

	// Updates the history with one frame and returns the expected vote.
	function automatic vote_t vote_for_frame(input frame_t f);
		vote_t       v;
		int unsigned mx;
		logic [15:0] ex [ClassCount];
		logic [63:0] ex_sum;
		logic [63:0] c;
		logic [63:0] tally [ClassCount];
		logic [95:0] t;
		logic [63:0] p;
		logic [63:0] w;
		int          len;
		int          cnt;
		int          s;
		int unsigned k;
		mx = 0;
		v.raw_class = 0;
		for (int i = 0; i < ClassCount; i++) begin
			if (f.score[i] > mx) begin
				mx = f.score[i];
				v.raw_class = 4'(i);
			end
		end
		ring_head = (ring_head + 1) % WindowMax;
		if (ring_fill < WindowMax) ring_fill++;
		if (mx == 0) begin
			for (int i = 0; i < ClassCount; i++)
				cert_ring[ring_head][i] = 16'((65536 + ClassCount / 2) / ClassCount);
		end else begin
			ex_sum = 0;
			for (int i = 0; i < ClassCount; i++) begin
				k = (255 * f.score[i] + mx / 2) / mx;
				if (k > 255) k = 255;
				ex[i] = exp_of_level(k);
				ex_sum += ex[i];
			end
			for (int i = 0; i < ClassCount; i++) begin
				c = ((64'(ex[i]) << 16) + ex_sum / 2) / ex_sum;
				if (c > 65535) c = 65535;
				cert_ring[ring_head][i] = 16'(c);
			end
		end
		len = window_reg;
		if (len < 1) len = 1;
		if (len > WindowMax) len = WindowMax;
		cnt = (ring_fill < len) ? ring_fill : len;
		for (int i = 0; i < ClassCount; i++) tally[i] = 0;
		p = 64'd1 << 32;
		for (int a = 0; a < cnt; a++) begin
			s = (ring_head + WindowMax - a) % WindowMax;
			if (a == 0) begin
				w = 65536;
			end else begin
				t = 96'(p) * 96'd3516421809 + (96'd1 << 31);
				p = 64'(t >> 32);
				w = (p + (64'd1 << 15)) >> 16;
			end
			for (int i = 0; i < ClassCount; i++)
				tally[i] += w * cert_ring[s][i];
		end
		v.smoothed_class = 0;
		for (int i = 1; i < ClassCount; i++)
			if (tally[i] > tally[v.smoothed_class]) v.smoothed_class = 4'(i);
		return v;
	endfunction

	function automatic frame_t uniform_frame(input logic [15:0] val);
		frame_t f;
		for (int i = 0; i < ClassCount; i++) f.score[i] = val;
		return f;
	endfunction

	// Random frame: a mix of full-range, narrow-range, sparse, small, saturated and two-level scores.
	function automatic frame_t random_frame();
		frame_t f;
		int     mode;
		int     base;
		mode = $urandom_range(0, 9);
		base = $urandom_range(0, 65000);
		for (int i = 0; i < ClassCount; i++) begin
			case (mode)
				0, 1, 2, 3: f.score[i] = 16'($urandom);
				4, 5: f.score[i] = 16'(base + $urandom_range(0, 500));
				6: f.score[i] = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'd0;
				7: f.score[i] = 16'($urandom_range(0, 7));
				8: f.score[i] = ($urandom_range(0, 2) == 0) ? 16'hFFFF : 16'($urandom);
				default: f.score[i] = ($urandom_range(0, 1) == 0) ? 16'(base) : 16'(base / 2);
			endcase
		end
		return f;
	endfunction

	task automatic add_frame(input frame_t f, input bit no_idle);
		pending_t p;
		p.act = ACT_FRAME;
		p.frame = f;
		p.window = 0;
		p.no_idle = no_idle;
		pending_q.insert(pending_q.size(), p);
	endtask

	task automatic add_window(input logic [4:0] wl);
		pending_t p;
		p.act = ACT_DRAIN;
		p.frame = uniform_frame(0);
		p.window = 0;
		p.no_idle = 0;
		pending_q.insert(pending_q.size(), p);
		p.act = ACT_WINDOW;
		p.window = wl;
		pending_q.insert(pending_q.size(), p);
	endtask

	// Fill the queue of pending items.
	initial begin
		frame_t f;
		logic [4:0] settings [6];
		settings = '{5'd1, 5'd16, 5'd0, 5'd31, 5'd5, 5'd12};
		// Directed frames: zeros, extremes, ties and single hot classes.
		add_frame(uniform_frame(16'd0), 0);
		add_frame(uniform_frame(16'hFFFF), 0);
		add_frame(uniform_frame(16'd1), 0);
		for (int i = 0; i < ClassCount; i++) begin
			f = uniform_frame(16'd0);
			f.score[i] = 16'hFFFF;
			add_frame(f, 0);
		end
		f = uniform_frame(16'h5555);
		f.score[3] = 16'hAAAA;
		f.score[7] = 16'hAAAA;
		add_frame(f, 0);
		f = uniform_frame(16'd1);
		f.score[9] = 16'd2;
		add_frame(f, 0);
		for (int i = 0; i < 5; i++) begin
			f = uniform_frame(16'd0);
			f.score[9 - i] = 16'd40000;
			f.score[i] = 16'd39999;
			add_frame(f, 0);
		end
		// Random frames across several window settings, extremes included.
		for (int s = 0; s < 6; s++) begin
			add_window(settings[s]);
			for (int n = 0; n < 263; n++) add_frame(random_frame(), 0);
		end
		// A pause until every vote has come back, then an idle-free stretch.
		add_window(5'($urandom_range(1, 16)));
		for (int n = 0; n < 150; n++) add_frame(random_frame(), 1);
		stim_done = 0;
	end

	// Driver: items and register writes leave on the falling edge.
	int  send_gap;
	int  drain_wait;
	bit  in_taken;
	bit  cfg_taken;
	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = 5'd0;
		for (int i = 0; i < ClassCount; i++) score[i] = 16'd0;
		out_ready = 1'b0;
		send_gap = 0;
		ring_fill = 0;
		ring_head = 0;
		window_reg = WindowReset;
		errors = 0;
		frames_sent = 0;
		votes_seen = 0;
		windows_written = 0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	// Handshakes seen at the rising edge, for the driver at the next falling edge.
	always @(posedge clk) begin
		in_taken <= in_valid && in_ready;
		cfg_taken <= cfg_valid && cfg_ready;
	end

	always @(negedge clk) begin
		bit in_next;
		bit cfg_next;
		if (arst_n) begin
			in_next = in_valid && !in_taken;
			cfg_next = cfg_valid && !cfg_taken;
			if (in_next || cfg_next) begin
				// Hold the item until it is taken.
			end else if (send_gap > 0) begin
				send_gap <= send_gap - 1;
			end else if (pending_q.size() > 0) begin
				case (pending_q[0].act)
					ACT_DRAIN: begin
						if (vote_q.size() == 0) begin
							if (drain_wait >= ItemLatency) begin
								drain_wait <= 0;
								void'(pending_q.pop_front());
							end else begin
								drain_wait <= drain_wait + 1;
							end
						end
					end
					ACT_WINDOW: begin
						cfg_data <= pending_q[0].window;
						cfg_next = 1'b1;
						void'(pending_q.pop_front());
					end
					default: begin
						for (int i = 0; i < ClassCount; i++)
							score[i] <= pending_q[0].frame.score[i];
						in_next = 1'b1;
						if (!pending_q[0].no_idle && $urandom_range(0, 5) == 0)
							send_gap <= $urandom_range(1, 14);
						void'(pending_q.pop_front());
					end
				endcase
			end else begin
				stim_done <= 1'b1;
			end
			in_valid <= in_next;
			cfg_valid <= cfg_next;
		end
	end

	// Receiver back-pressure in random bursts; none once the queue runs low.
	int stall_left;
	always @(negedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			stall_left <= 0;
		end else if (stall_left > 0) begin
			out_ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (pending_q.size() > 150 && $urandom_range(0, 7) == 0) begin
			out_ready <= 1'b0;
			stall_left <= $urandom_range(0, 13);
		end else begin
			out_ready <= 1'b1;
		end
	end

	// Monitor: accepted items feed the predictor, accepted votes are checked.
	always @(posedge clk) begin
		vote_t expv;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				window_reg = cfg_data;
				windows_written++;
			end
			if (in_valid && in_ready) begin
				frame_t f;
				for (int i = 0; i < ClassCount; i++) f.score[i] = score[i];
				vote_q.insert(vote_q.size(), vote_for_frame(f));
				frames_sent++;
			end
			if (out_valid && out_ready) begin
				votes_seen++;
				if (vote_q.size() == 0) begin
					$error("vote with no frame outstanding: raw_class %0d smoothed_class %0d",
						raw_class, smoothed_class);
					errors++;
				end else begin
					expv = vote_q.pop_front();
					if (raw_class !== expv.raw_class) begin
						$error("raw_class expected %0d actual %0d", expv.raw_class, raw_class);
						errors++;
					end
					if (smoothed_class !== expv.smoothed_class) begin
						$error("smoothed_class expected %0d actual %0d",
							expv.smoothed_class, smoothed_class);
						errors++;
					end
				end
			end
		end
	end

	// Watchdog on cycles with no handshake at all.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)
				|| (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= StallLimit) begin
			$display("decayed_softmax_class_vote_tb: FAIL");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// End of run.
	initial begin
		drain_wait = 0;
		quiet_cycles = 0;
		while (!(stim_done && vote_q.size() == 0)) @(posedge clk);
		repeat (ItemLatency) @(posedge clk);
		if (vote_q.size() != 0) begin
			$error("%0d votes never arrived", vote_q.size());
			errors++;
		end
		$display("Sent %0d frames and checked %0d votes over %0d window settings.",
			frames_sent, votes_seen, windows_written);
		if (errors == 0) begin
			$display("decayed_softmax_class_vote_tb: PASS");
		end else begin
			$display("decayed_softmax_class_vote_tb: FAIL");
		end
		$finish;
	end

endmodule

/* filelist.f */
hdl/dscv_pkg.sv
hdl/dscv_divider.sv
hdl/decayed_softmax_class_vote.sv
dv/decayed_softmax_class_vote_tb.sv
